FILE: sv/ffa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state codes for the first-fit heap allocator.
package ffa_pkg;

  // Heap geometry
  localparam int HEAP_BYTES = 65536;
  localparam int ALIGN_BYTES = 8;
  localparam int ALIGN_SH = 3;
  localparam int HEADER_BYTES = 32;
  localparam int HDR = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int NU = HEAP_BYTES / ALIGN_BYTES;
  localparam int IDX_W = $clog2(NU);
  localparam int SIZE_W = 17;
  localparam int NEED_W = 33;
  localparam int PROD_W = 32;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INIT  = 2'd2
  } ffa_cmd_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OOM         = 2'd1,
    ST_BAD_MARK    = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } ffa_status_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HEAP_BASE    = 2'd0,
    CFG_HEAP_BYTES   = 2'd1,
    CFG_SPLIT_MARGIN = 2'd2
  } ffa_cfg_idx_e;

  // Return points of the coalescing routine
  typedef enum logic [1:0] {
    RET_FREE0,
    RET_FREEB,
    RET_PASS
  } ffa_ret_e;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_CLR,
    S_A_HRD,
    S_A_HCHK,
    S_FF_RD,
    S_FF_CHK,
    S_P_RD,
    S_P_CHK,
    S_A_TAKE,
    S_A_DEC,
    S_A_NBWR,
    S_A_NXRD,
    S_A_NXWR,
    S_A_UWR,
    S_F_OFF,
    S_F_RD,
    S_F_CHK,
    S_F_WR,
    S_C_RD,
    S_C_CHK,
    S_C_BK,
    S_C_BKCHK,
    S_C_FW,
    S_C_FWCHK,
    S_C_JOIN,
    S_C_MK,
    S_C_MKWR,
    S_C_FWR,
    S_C_NRD,
    S_C_NWR,
    S_DONE
  } ffa_state_e;

  // One block header
  typedef struct packed {
    logic              mark;
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  nxt;
    logic [IDX_W-1:0]  prv;
    logic              hasn;
    logic              hasp;
  } ffa_hdr_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] elem_length;
    logic [15:0] elem_count;
    logic [31:0] free_address;
  } ffa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       data_address;
    logic [SIZE_W-1:0] allocated_bytes;
  } ffa_out_t;

  typedef struct packed {
    logic [31:0]       heap_base;
    logic [SIZE_W-1:0] heap_bytes;
    logic [12:0]       split_margin;
  } ffa_cfg_t;

  // Engine status toward the channel logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } ffa_eng_sts_t;

endpackage

FILE: sv/ffa_size.sv
`timescale 1ns / 1ps
// Request size unit: length times count, rounded up to the alignment.
module ffa_size (
  input  logic                       clk,
  input  logic                       load,
  input  logic [15:0]                elem_length,
  input  logic [15:0]                elem_count,
  output logic [ffa_pkg::NEED_W-1:0] need
);

  logic [ffa_pkg::PROD_W-1:0] prod_r;
  logic [ffa_pkg::NEED_W-1:0] need_r;
  logic [ffa_pkg::NEED_W-1:0] rnd;

  // Product stage
  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= ffa_pkg::PROD_W'(elem_length) * ffa_pkg::PROD_W'(elem_count);
    end
  end

  // Zero counts as one unit, then round up
  always_comb begin
    if (prod_r == '0) begin
      rnd = ffa_pkg::NEED_W'(ffa_pkg::ALIGN_BYTES);
    end else begin
      rnd = ffa_pkg::NEED_W'(prod_r) + ffa_pkg::NEED_W'(ffa_pkg::ALIGN_BYTES - 1);
      rnd[ffa_pkg::ALIGN_SH-1:0] = '0;
    end
  end

  always_ff @(posedge clk) begin
    need_r <= rnd;
  end

  assign need = need_r;

endmodule

FILE: sv/ffa_engine.sv
`timescale 1ns / 1ps
// Header-walk sequencer with the header memory, search, split, free and coalescing.
module ffa_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  ffa_pkg::ffa_in_t           item,
  input  ffa_pkg::ffa_cfg_t          cfg,
  input  logic [ffa_pkg::NEED_W-1:0] need,
  input  logic                       slot_free,
  output ffa_pkg::ffa_eng_sts_t      sts,
  output ffa_pkg::ffa_out_t          result
);

  localparam int IW = ffa_pkg::IDX_W;
  localparam int SW = ffa_pkg::SIZE_W;

  ffa_pkg::ffa_state_e state_r, state_nxt, ret_state;

  // Header memory
  ffa_pkg::ffa_hdr_t mem [ffa_pkg::NU];
  ffa_pkg::ffa_hdr_t rq_r;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  ffa_pkg::ffa_hdr_t wr_data;

  // Sequencer registers
  logic [1:0]        cmd_r;
  logic [31:0]       faddr_r;
  logic [1:0]        st_r;
  logic [31:0]       addr_r;
  logic [SW-1:0]     held_r;
  logic [IW-1:0]     hint_r;
  logic [IW-1:0]     clr_idx_r;
  logic              clr_cmd_r;
  logic [IW-1:0]     c_r, pc_r, u_r, nb_r, co_b_r, f_r, l_r, b_r;
  logic              pass_done_r, split_r;
  logic [SW-1:0]     excess_r, size_r;
  ffa_pkg::ffa_ret_e co_ret_r;
  ffa_pkg::ffa_hdr_t u_hdr_r, f_hdr_r, l_hdr_r, c_hdr_r;

  // Helpers
  logic              fit, split, off_bad;
  logic [31:0]       off;
  logic [SW-1:0]     ms, ms_al, init_size;
  logic [IW-1:0]     nb;
  ffa_pkg::ffa_hdr_t init_hdr;

  assign fit = !rq_r.used && (ffa_pkg::NEED_W'(rq_r.size) >= need);
  assign split = (excess_r > SW'(cfg.split_margin)) && (excess_r >= SW'(ffa_pkg::HDR));
  assign nb = u_r + IW'((need[SW-1:0] + SW'(ffa_pkg::HDR)) >> ffa_pkg::ALIGN_SH);
  assign off = faddr_r - cfg.heap_base - 32'(ffa_pkg::HDR);
  assign off_bad = (off >= 32'(ffa_pkg::HEAP_BYTES)) || (off[ffa_pkg::ALIGN_SH-1:0] != '0);

  // Initial block size from the configured heap size
  always_comb begin
    ms = (cfg.heap_bytes > SW'(ffa_pkg::HEAP_BYTES)) ? SW'(ffa_pkg::HEAP_BYTES) : cfg.heap_bytes;
    ms_al = ms;
    ms_al[ffa_pkg::ALIGN_SH-1:0] = '0;
    init_size = (ms_al > SW'(ffa_pkg::HDR)) ? ms_al - SW'(ffa_pkg::HDR) : '0;
    init_hdr = '0;
    init_hdr.mark = 1'b1;
    init_hdr.size = init_size;
  end

  // Memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rq_r <= mem[rd_addr];
  end

  // Where the coalescing routine goes back to
  always_comb begin
    unique case (co_ret_r)
      ffa_pkg::RET_FREE0: ret_state = ffa_pkg::S_F_OFF;
      ffa_pkg::RET_FREEB: ret_state = ffa_pkg::S_DONE;
      default:            ret_state = ffa_pkg::S_P_RD;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (start) begin
          case (item.cmd)
            ffa_pkg::CMD_ALLOC: state_nxt = ffa_pkg::S_A_HRD;
            ffa_pkg::CMD_FREE:  state_nxt = ffa_pkg::S_C_RD;
            ffa_pkg::CMD_INIT:  state_nxt = ffa_pkg::S_CLR;
            default:            state_nxt = ffa_pkg::S_DONE;
          endcase
        end
      end
      ffa_pkg::S_CLR: begin
        if (clr_idx_r == '1) begin
          state_nxt = clr_cmd_r ? ffa_pkg::S_DONE : ffa_pkg::S_IDLE;
        end
      end
      ffa_pkg::S_A_HRD:  state_nxt = ffa_pkg::S_A_HCHK;
      ffa_pkg::S_A_HCHK: state_nxt = ffa_pkg::S_FF_RD;
      ffa_pkg::S_FF_RD:  state_nxt = ffa_pkg::S_FF_CHK;
      ffa_pkg::S_FF_CHK: begin
        if (fit) begin
          state_nxt = ffa_pkg::S_A_TAKE;
        end else if (!rq_r.hasn) begin
          state_nxt = pass_done_r ? ffa_pkg::S_DONE : ffa_pkg::S_C_RD;
        end else begin
          state_nxt = ffa_pkg::S_FF_RD;
        end
      end
      ffa_pkg::S_P_RD:   state_nxt = ffa_pkg::S_P_CHK;
      ffa_pkg::S_P_CHK:  state_nxt = rq_r.hasn ? ffa_pkg::S_C_RD : ffa_pkg::S_FF_RD;
      ffa_pkg::S_A_TAKE: state_nxt = ffa_pkg::S_A_DEC;
      ffa_pkg::S_A_DEC:  state_nxt = split ? ffa_pkg::S_A_NBWR : ffa_pkg::S_A_UWR;
      ffa_pkg::S_A_NBWR: state_nxt = u_hdr_r.hasn ? ffa_pkg::S_A_NXRD : ffa_pkg::S_A_UWR;
      ffa_pkg::S_A_NXRD: state_nxt = ffa_pkg::S_A_NXWR;
      ffa_pkg::S_A_NXWR: state_nxt = ffa_pkg::S_A_UWR;
      ffa_pkg::S_A_UWR:  state_nxt = ffa_pkg::S_DONE;
      ffa_pkg::S_F_OFF: begin
        if (faddr_r == '0 || off_bad) begin
          state_nxt = ffa_pkg::S_DONE;
        end else begin
          state_nxt = ffa_pkg::S_F_RD;
        end
      end
      ffa_pkg::S_F_RD: state_nxt = ffa_pkg::S_F_CHK;
      ffa_pkg::S_F_CHK: begin
        if (!rq_r.mark) begin
          state_nxt = ffa_pkg::S_DONE;
        end else if (rq_r.used) begin
          state_nxt = ffa_pkg::S_F_WR;
        end else begin
          state_nxt = ffa_pkg::S_C_RD;
        end
      end
      ffa_pkg::S_F_WR:    state_nxt = ffa_pkg::S_C_RD;
      ffa_pkg::S_C_RD:    state_nxt = ffa_pkg::S_C_CHK;
      ffa_pkg::S_C_CHK:   state_nxt = rq_r.used ? ret_state : ffa_pkg::S_C_BK;
      ffa_pkg::S_C_BK:    state_nxt = f_hdr_r.hasp ? ffa_pkg::S_C_BKCHK : ffa_pkg::S_C_FW;
      ffa_pkg::S_C_BKCHK: state_nxt = rq_r.used ? ffa_pkg::S_C_FW : ffa_pkg::S_C_BK;
      ffa_pkg::S_C_FW:    state_nxt = l_hdr_r.hasn ? ffa_pkg::S_C_FWCHK : ffa_pkg::S_C_JOIN;
      ffa_pkg::S_C_FWCHK: state_nxt = rq_r.used ? ffa_pkg::S_C_JOIN : ffa_pkg::S_C_FW;
      ffa_pkg::S_C_JOIN:  state_nxt = (f_r == l_r) ? ret_state : ffa_pkg::S_C_MK;
      ffa_pkg::S_C_MK: begin
        if (c_r == l_r || !c_hdr_r.hasn) begin
          state_nxt = ffa_pkg::S_C_FWR;
        end else begin
          state_nxt = ffa_pkg::S_C_MKWR;
        end
      end
      ffa_pkg::S_C_MKWR: state_nxt = ffa_pkg::S_C_MK;
      ffa_pkg::S_C_FWR:  state_nxt = l_hdr_r.hasn ? ffa_pkg::S_C_NRD : ret_state;
      ffa_pkg::S_C_NRD:  state_nxt = ffa_pkg::S_C_NWR;
      ffa_pkg::S_C_NWR:  state_nxt = ret_state;
      ffa_pkg::S_DONE:   state_nxt = slot_free ? ffa_pkg::S_IDLE : ffa_pkg::S_DONE;
      default:           state_nxt = ffa_pkg::S_IDLE;
    endcase
  end

  // Memory port controls
  always_comb begin
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state_r)
      ffa_pkg::S_CLR: begin
        wr_en = 1'b1;
        wr_addr = clr_idx_r;
        wr_data = (clr_idx_r == '0) ? init_hdr : '0;
      end
      ffa_pkg::S_A_HRD: rd_addr = hint_r;
      ffa_pkg::S_FF_RD: rd_addr = c_r;
      ffa_pkg::S_P_RD:  rd_addr = pc_r;
      ffa_pkg::S_A_NBWR: begin
        wr_en = 1'b1;
        wr_addr = nb_r;
        wr_data.mark = 1'b1;
        wr_data.used = 1'b0;
        wr_data.size = excess_r - SW'(ffa_pkg::HDR);
        wr_data.nxt = u_hdr_r.nxt;
        wr_data.hasn = u_hdr_r.hasn;
        wr_data.prv = u_r;
        wr_data.hasp = 1'b1;
      end
      ffa_pkg::S_A_NXRD: rd_addr = u_hdr_r.nxt;
      ffa_pkg::S_A_NXWR: begin
        wr_en = 1'b1;
        wr_addr = u_hdr_r.nxt;
        wr_data = rq_r;
        wr_data.prv = nb_r;
      end
      ffa_pkg::S_A_UWR: begin
        wr_en = 1'b1;
        wr_addr = u_r;
        wr_data = u_hdr_r;
        wr_data.used = 1'b1;
        if (split_r) begin
          wr_data.nxt = nb_r;
          wr_data.hasn = 1'b1;
          wr_data.size = need[SW-1:0];
        end
      end
      ffa_pkg::S_F_RD: rd_addr = b_r;
      ffa_pkg::S_F_WR: begin
        wr_en = 1'b1;
        wr_addr = b_r;
        wr_data = u_hdr_r;
        wr_data.used = 1'b0;
      end
      ffa_pkg::S_C_RD: rd_addr = co_b_r;
      ffa_pkg::S_C_BK: rd_addr = f_hdr_r.prv;
      ffa_pkg::S_C_FW: rd_addr = l_hdr_r.nxt;
      ffa_pkg::S_C_MK: rd_addr = c_hdr_r.nxt;
      ffa_pkg::S_C_MKWR: begin
        wr_en = 1'b1;
        wr_addr = c_r;
        wr_data = rq_r;
        wr_data.mark = 1'b0;
      end
      ffa_pkg::S_C_FWR: begin
        wr_en = 1'b1;
        wr_addr = f_r;
        wr_data = f_hdr_r;
        wr_data.size = size_r;
        wr_data.nxt = l_hdr_r.nxt;
        wr_data.hasn = l_hdr_r.hasn;
      end
      ffa_pkg::S_C_NRD: rd_addr = l_hdr_r.nxt;
      ffa_pkg::S_C_NWR: begin
        wr_en = 1'b1;
        wr_addr = l_hdr_r.nxt;
        wr_data = rq_r;
        wr_data.prv = f_r;
        wr_data.hasp = 1'b1;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // State register and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffa_pkg::S_CLR;
      clr_idx_r <= '0;
      clr_cmd_r <= 1'b0;
      held_r <= '0;
      hint_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ffa_pkg::S_IDLE && start && item.cmd == ffa_pkg::CMD_INIT) begin
        clr_idx_r <= '0;
        clr_cmd_r <= 1'b1;
      end else if (state_r == ffa_pkg::S_CLR) begin
        clr_idx_r <= clr_idx_r + IW'(1);
        held_r <= '0;
        hint_r <= '0;
      end else if (state_r == ffa_pkg::S_A_UWR) begin
        held_r <= split_r ? held_r + need[SW-1:0] : held_r + u_hdr_r.size;
        if (split_r) begin
          hint_r <= nb_r;
        end
      end else if (state_r == ffa_pkg::S_F_CHK && rq_r.mark && rq_r.used) begin
        held_r <= (held_r >= rq_r.size) ? held_r - rq_r.size : '0;
      end else if (state_r == ffa_pkg::S_C_JOIN) begin
        hint_r <= f_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ffa_pkg::S_IDLE: begin
        if (start) begin
          cmd_r <= item.cmd;
          faddr_r <= item.free_address;
          st_r <= ffa_pkg::ST_OK;
          addr_r <= '0;
          pass_done_r <= 1'b0;
          co_b_r <= '0;
          co_ret_r <= ffa_pkg::RET_FREE0;
        end
      end
      ffa_pkg::S_A_HCHK: c_r <= rq_r.mark ? hint_r : '0;
      ffa_pkg::S_FF_CHK: begin
        if (fit) begin
          u_r <= c_r;
          u_hdr_r <= rq_r;
        end else if (!rq_r.hasn) begin
          if (pass_done_r) begin
            st_r <= ffa_pkg::ST_OOM;
          end else begin
            pc_r <= '0;
            co_b_r <= '0;
            co_ret_r <= ffa_pkg::RET_PASS;
          end
        end else begin
          c_r <= rq_r.nxt;
        end
      end
      ffa_pkg::S_P_CHK: begin
        if (!rq_r.hasn) begin
          pass_done_r <= 1'b1;
          c_r <= '0;
        end else begin
          pc_r <= rq_r.nxt;
          co_b_r <= rq_r.nxt;
        end
      end
      ffa_pkg::S_A_TAKE: excess_r <= u_hdr_r.size - need[SW-1:0];
      ffa_pkg::S_A_DEC: begin
        split_r <= split;
        nb_r <= nb;
      end
      ffa_pkg::S_A_UWR: begin
        addr_r <= cfg.heap_base + (32'(u_r) << ffa_pkg::ALIGN_SH) + 32'(ffa_pkg::HDR);
      end
      ffa_pkg::S_F_OFF: begin
        b_r <= off[ffa_pkg::ALIGN_SH +: IW];
        co_b_r <= off[ffa_pkg::ALIGN_SH +: IW];
        co_ret_r <= ffa_pkg::RET_FREEB;
        if (faddr_r != '0 && off_bad) begin
          st_r <= ffa_pkg::ST_BAD_MARK;
        end
      end
      ffa_pkg::S_F_CHK: begin
        u_hdr_r <= rq_r;
        if (!rq_r.mark) begin
          st_r <= ffa_pkg::ST_BAD_MARK;
        end else if (!rq_r.used) begin
          st_r <= ffa_pkg::ST_DOUBLE_FREE;
        end
      end
      ffa_pkg::S_C_CHK: begin
        f_r <= co_b_r;
        l_r <= co_b_r;
        f_hdr_r <= rq_r;
        l_hdr_r <= rq_r;
      end
      ffa_pkg::S_C_BKCHK: begin
        if (!rq_r.used) begin
          f_r <= f_hdr_r.prv;
          f_hdr_r <= rq_r;
        end
      end
      ffa_pkg::S_C_FWCHK: begin
        if (!rq_r.used) begin
          l_r <= l_hdr_r.nxt;
          l_hdr_r <= rq_r;
        end
      end
      ffa_pkg::S_C_JOIN: begin
        size_r <= SW'({l_r - f_r, {ffa_pkg::ALIGN_SH{1'b0}}}) + l_hdr_r.size;
        c_r <= f_r;
        c_hdr_r <= f_hdr_r;
      end
      ffa_pkg::S_C_MK: begin
        if (c_r != l_r && c_hdr_r.hasn) begin
          c_r <= c_hdr_r.nxt;
        end
      end
      ffa_pkg::S_C_MKWR: c_hdr_r <= rq_r;
      default: begin
        cmd_r <= cmd_r;
      end
    endcase
  end

  assign sts.idle = (state_r == ffa_pkg::S_IDLE);
  assign sts.res_valid = (state_r == ffa_pkg::S_DONE);
  assign result.status = st_r;
  assign result.data_address = (cmd_r == ffa_pkg::CMD_ALLOC) ? addr_r : '0;
  assign result.allocated_bytes = held_r;

endmodule

FILE: sv/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
// Top level: channels, configuration registers, result register.
// Search: first-fit from the hint block; a failed first-fit search adds a coalescing pass
//   over the whole chain, then a second search from the first block.
// Throughput: one transaction at a time, on one read and one write memory port.
// Reset and the heap-init command run a clearing sweep over all 8192 header memory
//   entries, during which no transaction is accepted; config writes still land.
module first_fit_heap_allocator (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ffa_pkg::ffa_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ffa_pkg::ffa_out_t out_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_wdata
);

  ffa_pkg::ffa_cfg_t          cfg_r;
  ffa_pkg::ffa_eng_sts_t      sts;
  ffa_pkg::ffa_out_t          res;
  ffa_pkg::ffa_out_t          out_r;
  logic                       out_valid_r;
  logic                       accept, slot_free, take;
  logic [ffa_pkg::NEED_W-1:0] need;

  assign in_stall = !sts.idle;
  assign accept = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign take = sts.res_valid && slot_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.heap_base <= '0;
      cfg_r.heap_bytes <= ffa_pkg::SIZE_W'(ffa_pkg::HEAP_BYTES);
      cfg_r.split_margin <= 13'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ffa_pkg::CFG_HEAP_BASE:    cfg_r.heap_base <= cfg_wdata;
        ffa_pkg::CFG_HEAP_BYTES:   cfg_r.heap_bytes <= cfg_wdata[ffa_pkg::SIZE_W-1:0];
        ffa_pkg::CFG_SPLIT_MARGIN: cfg_r.split_margin <= cfg_wdata[12:0];
        default:                   cfg_r <= cfg_r;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  ffa_size u_size (
    .clk         (clk),
    .load        (accept),
    .elem_length (in_data.elem_length),
    .elem_count  (in_data.elem_count),
    .need        (need)
  );

  ffa_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .item      (in_data),
    .cfg       (cfg_r),
    .need      (need),
    .slot_free (slot_free),
    .sts       (sts),
    .result    (res)
  );

endmodule

FILE: tb/sv/ffa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the heap allocator: predicts each transaction and compares results.
module ffa_checker
  import ffa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  ffa_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  ffa_out_t out_data,
  input  logic     cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int       fail_count,
  output int       expect_depth
);

  localparam int unsigned NO_BLK = 32'hFFFF_FFFF;

  // Shadow copy of the header chain
  bit          blk_mark [NU];
  bit          blk_used [NU];
  int unsigned blk_size [NU];
  int unsigned blk_next [NU];
  int unsigned blk_prev [NU];
  bit          blk_hasn [NU];
  bit          blk_hasp [NU];
  int unsigned free_hint;
  int unsigned held_total;

  // Shadow configuration
  int unsigned base_addr;
  int unsigned heap_len;
  int unsigned margin;

  ffa_out_t expected_results[$];

  task automatic report(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int unsigned wrap(input int unsigned i);
    return i % NU;
  endfunction

  // Clear every header and lay out one free block over the whole heap
  function automatic void init_heap();
    int unsigned ms;
    ms = heap_len;
    for (int i = 0; i < NU; i++) begin
      blk_mark[i] = 0;
      blk_used[i] = 0;
      blk_size[i] = 0;
      blk_next[i] = 0;
      blk_prev[i] = 0;
      blk_hasn[i] = 0;
      blk_hasp[i] = 0;
    end
    if (ms > HEAP_BYTES) ms = HEAP_BYTES;
    ms = (ms / ALIGN_BYTES) * ALIGN_BYTES;
    blk_mark[0] = 1;
    blk_size[0] = (ms > HDR) ? ms - HDR : 0;
    free_hint = 0;
    held_total = 0;
  endfunction

  // Merge the free run around block b into its first block
  function automatic void merge_run(input int unsigned b);
    int unsigned f, l, c;
    int n;
    f = wrap(b);
    l = f;
    if (blk_used[f]) return;
    n = 0;
    while (n < NU && blk_hasp[f] && !blk_used[wrap(blk_prev[f])]) begin
      f = wrap(blk_prev[f]);
      n++;
    end
    free_hint = f;
    n = 0;
    while (n < NU && blk_hasn[l] && !blk_used[wrap(blk_next[l])]) begin
      l = wrap(blk_next[l]);
      n++;
    end
    if (f == l) return;
    blk_size[f] = (l - f) * ALIGN_BYTES + blk_size[l];
    // absorbed headers lose their mark
    c = f;
    n = 0;
    while (n < NU && c != l && blk_hasn[c]) begin
      c = wrap(blk_next[c]);
      blk_mark[c] = 0;
      n++;
    end
    blk_hasn[f] = blk_hasn[l];
    blk_next[f] = blk_next[l];
    if (blk_hasn[l]) begin
      blk_prev[wrap(blk_next[l])] = f;
      blk_hasp[wrap(blk_next[l])] = 1;
    end
  endfunction

  function automatic int unsigned first_fit(input int unsigned start,
                                            input longint unsigned need);
    int unsigned c;
    c = wrap(start);
    for (int n = 0; n < NU; n++) begin
      if (!blk_used[c] && longint'(blk_size[c]) >= need) return c;
      if (!blk_hasn[c]) return NO_BLK;
      c = wrap(blk_next[c]);
    end
    return NO_BLK;
  endfunction

  function automatic logic [1:0] alloc_block(input int unsigned len, input int unsigned cnt,
                                             output int unsigned addr);
    longint unsigned need;
    int unsigned u, c, excess, nb;
    addr = 0;
    need = longint'(len) * longint'(cnt);
    if (need == 0) need = ALIGN_BYTES;
    need = ((need + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    u = first_fit(blk_mark[wrap(free_hint)] ? free_hint : 0, need);
    // miss: coalesce the whole chain and retry from the first block
    if (u == NO_BLK) begin
      c = 0;
      for (int n = 0; n < NU; n++) begin
        merge_run(c);
        if (!blk_hasn[c]) break;
        c = wrap(blk_next[c]);
      end
      u = first_fit(0, need);
      if (u == NO_BLK) return ST_OOM;
    end
    blk_used[u] = 1;
    held_total += blk_size[u];
    excess = blk_size[u] - int'(need);
    if (excess > margin && excess >= HDR) begin
      nb = wrap(u + (int'(need) + HDR) / ALIGN_BYTES);
      blk_mark[nb] = 1;
      blk_used[nb] = 0;
      blk_size[nb] = excess - HDR;
      blk_next[nb] = blk_next[u];
      blk_hasn[nb] = blk_hasn[u];
      blk_prev[nb] = u;
      blk_hasp[nb] = 1;
      if (blk_hasn[u]) blk_prev[wrap(blk_next[u])] = nb;
      blk_next[u] = nb;
      blk_hasn[u] = 1;
      blk_size[u] = int'(need);
      held_total -= excess;
      free_hint = nb;
    end
    addr = base_addr + u * ALIGN_BYTES + HDR;
    return ST_OK;
  endfunction

  function automatic logic [1:0] free_block(input int unsigned a);
    int unsigned off, b;
    logic [1:0] st;
    st = ST_OK;
    merge_run(0);
    if (a == 0) return ST_OK;
    off = a - base_addr - HDR;
    if (off >= HEAP_BYTES || off % ALIGN_BYTES != 0) return ST_BAD_MARK;
    b = wrap(off / ALIGN_BYTES);
    if (!blk_mark[b]) return ST_BAD_MARK;
    if (blk_used[b]) begin
      held_total = (held_total >= blk_size[b]) ? held_total - blk_size[b] : 0;
      blk_used[b] = 0;
    end else begin
      st = ST_DOUBLE_FREE;
    end
    merge_run(b);
    return st;
  endfunction

  function automatic ffa_out_t heap_result(input ffa_in_t t);
    ffa_out_t r;
    int unsigned a;
    r = '0;
    case (t.cmd)
      CMD_ALLOC: begin
        r.status = alloc_block(t.elem_length, t.elem_count, a);
        r.data_address = a;
      end
      CMD_FREE: r.status = free_block(t.free_address);
      CMD_INIT: init_heap();
      default: ;
    endcase
    r.allocated_bytes = held_total[SIZE_W-1:0];
    return r;
  endfunction

  // Watch the channels and the register port
  always @(posedge clk) begin
    ffa_out_t e;
    if (!rst_n) begin
      base_addr = 0;
      heap_len = 65536;
      margin = 128;
      init_heap();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("result transaction with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status)
            report($sformatf("status %0d, expected %0d", out_data.status, e.status));
          if (out_data.data_address !== e.data_address)
            report($sformatf("data_address %h, expected %h",
                             out_data.data_address, e.data_address));
          if (out_data.allocated_bytes !== e.allocated_bytes)
            report($sformatf("allocated_bytes %0d, expected %0d",
                             out_data.allocated_bytes, e.allocated_bytes));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAP_BASE:    base_addr = cfg_wdata;
          CFG_HEAP_BYTES:   heap_len = cfg_wdata[SIZE_W-1:0];
          CFG_SPLIT_MARGIN: margin = cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(heap_result(in_data));
    end
    expect_depth = expected_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top: drives alloc/free/init and config traffic to the allocator; gives verdict.
module tb;
  import ffa_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8300;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  ffa_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  ffa_out_t    out_data;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = CFG_HEAP_BASE;
  logic [31:0] cfg_wdata = '0;

  int fail_count;
  int expect_depth;
  int tx_count = 0;
  int rx_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int unsigned live_addrs[$];
  int unsigned freed_addrs[$];

  first_fit_heap_allocator i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ffa_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .expect_depth(expect_depth)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Count results and keep allocated addresses for later frees
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      rx_count <= rx_count + 1;
      if (out_data.data_address != 0) live_addrs.push_back(out_data.data_address);
    end
  end

  function automatic ffa_in_t mk(input logic [1:0] c, input int unsigned len,
                                 input int unsigned cnt, input int unsigned addr);
    ffa_in_t t;
    t.cmd = c;
    t.elem_length = len[15:0];
    t.elem_count = cnt[15:0];
    t.free_address = addr;
    return t;
  endfunction

  // Offer one transaction and wait until it is taken
  task automatic send(input ffa_in_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    tx_count++;
  endtask

  // Sender pause until every result is back
  task automatic drain();
    in_valid <= 0;
    while (rx_count != tx_count) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  function automatic ffa_in_t rand_alloc();
    int p;
    p = $urandom_range(99);
    if (p < 75)
      return mk(CMD_ALLOC, $urandom_range(0, 64), $urandom_range(0, 4), $urandom);
    if (p < 88)
      return mk(CMD_ALLOC, $urandom_range(0, 2048), $urandom_range(1, 8), $urandom);
    if (p < 94)
      return mk(CMD_ALLOC, 1, $urandom_range(0, 65535), $urandom);
    return mk(CMD_ALLOC, $urandom, $urandom, $urandom);
  endfunction

  function automatic ffa_in_t rand_free();
    int p, idx;
    int unsigned a;
    p = $urandom_range(99);
    a = $urandom;
    if (p < 65 && live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[idx];
      live_addrs.delete(idx);
      freed_addrs.push_back(a);
      if (freed_addrs.size() > 32) void'(freed_addrs.pop_front());
    end else if (p < 75 && freed_addrs.size() > 0) begin
      // repeat free: double free or an absorbed header
      a = freed_addrs[$urandom_range(0, freed_addrs.size() - 1)];
    end else if (p < 85) begin
      a = $urandom;
    end else if (p < 90) begin
      a = 0;
    end else if (live_addrs.size() > 0) begin
      a = live_addrs[$urandom_range(0, live_addrs.size() - 1)] + $urandom_range(1, 15);
    end
    return mk(CMD_FREE, $urandom, $urandom, a);
  endfunction

  function automatic ffa_in_t rand_item();
    int p;
    p = $urandom_range(199);
    if (p < 2) return mk(CMD_INIT, $urandom, $urandom, $urandom);
    if (p < 6) return mk(CMD_NONE, $urandom, $urandom, $urandom);
    if (p < 100) return rand_alloc();
    return rand_free();
  endfunction

  task automatic directed();
    int unsigned a, b;
    send(mk(CMD_ALLOC, 0, 0, 0));
    send(mk(CMD_ALLOC, 1, 1, 0));
    send(mk(CMD_ALLOC, 100, 3, 0));
    send(mk(CMD_ALLOC, 3, 3, 0));
    send(mk(CMD_ALLOC, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send(mk(CMD_ALLOC, 16'h8000, 2, 0));
    drain();
    a = (live_addrs.size() > 0) ? live_addrs[0] : HDR;
    b = (live_addrs.size() > 1) ? live_addrs[1] : HDR + 40;
    send(mk(CMD_FREE, 0, 0, a));
    send(mk(CMD_FREE, 0, 0, a));
    send(mk(CMD_FREE, 0, 0, b + 4));
    send(mk(CMD_FREE, 0, 0, b + 8));
    send(mk(CMD_FREE, 0, 0, 32'hFFFF_FFF8));
    send(mk(CMD_FREE, 0, 0, 0));
    send(mk(CMD_FREE, 0, 0, b));
    send(mk(CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    // whole heap: misses, also after coalescing, since other blocks stay in use
    send(mk(CMD_ALLOC, HEAP_BYTES - HDR, 1, 0));
    send(mk(CMD_ALLOC, 8, 1, 0));
    send(mk(CMD_INIT, 0, 0, 0));
    send(mk(CMD_ALLOC, 0, 1, 0));
    send(mk(CMD_FREE, 0, 0, 0));
    drain();
    live_addrs.delete();
  endtask

  // Stimulus
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    tx_idle_pct = 33;
    rx_idle_pct <= 65;
    directed();
    for (int phase = 0; phase < 4; phase++) begin
      if (phase > 0) begin
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        case (phase)
          1: begin
            cfg_write(CFG_HEAP_BASE, 32'hFFFF_FFFF);
            cfg_write(CFG_HEAP_BYTES, 256);
            cfg_write(CFG_SPLIT_MARGIN, 0);
          end
          2: begin
            cfg_write(CFG_HEAP_BASE, 32'h8000_0000);
            cfg_write(CFG_HEAP_BYTES, HEAP_BYTES);
            cfg_write(CFG_SPLIT_MARGIN, 4096);
          end
          default: begin
            cfg_write(CFG_HEAP_BASE, $urandom);
            cfg_write(CFG_HEAP_BYTES, $urandom_range(256, HEAP_BYTES));
            cfg_write(CFG_SPLIT_MARGIN, $urandom_range(0, 4096));
          end
        endcase
        cfg_we <= 0;
        live_addrs.delete();
        freed_addrs.delete();
        send(mk(CMD_INIT, 0, 0, 0));
      end
      if (phase == 2) begin
        tx_idle_pct = 65;
        rx_idle_pct <= 33;
      end else if (phase == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      for (int k = 0; k < 110; k++) begin
        if (phase == 0 && k == 40) hold_req <= hold_req + 1;
        send(rand_item());
      end
    end
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && expect_depth == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #300ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
sv/ffa_pkg.sv
sv/ffa_size.sv
sv/ffa_engine.sv
sv/first_fit_heap_allocator.sv
tb/sv/ffa_checker.sv
tb/sv/tb.sv
